>>> src/teb_pkg.sv
// Shared types and constants of the trace event ring buffer.
package teb_pkg;

  localparam int DEPTH_DEF    = 1024;
  localparam int MAX_READ_DEF = 64;

  localparam int ACT_W     = 3;
  localparam int KIND_W    = 2;
  localparam int CODE_W    = 64;
  localparam int POS_W     = 32;
  localparam int STAMP_W   = 64;
  localparam int RCNT_W    = 7;
  localparam int TOTAL_W   = 64;
  localparam int WIDX_W    = 10;
  localparam int CAP_W     = 11;
  localparam int CAP_RESET = 1024;

  localparam logic [ACT_W-1:0] ACT_RECORD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STOP   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  localparam logic RES_STATUS = 1'b0;
  localparam logic RES_EVENT  = 1'b1;

  typedef struct packed {
    logic [STAMP_W-1:0]      stamp;
    logic [CODE_W-1:0]       code;
    logic signed [POS_W-1:0] position;
    logic [KIND_W-1:0]       kind;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

endpackage

>>> src/teb_in_if.sv
// Input channel of the trace event ring buffer: one action per transfer.
interface teb_in_if;
  logic                             valid;
  logic                             ready;
  logic [teb_pkg::ACT_W-1:0]        action;
  logic [teb_pkg::KIND_W-1:0]       event_kind;
  logic [teb_pkg::CODE_W-1:0]       code_identity;
  logic signed [teb_pkg::POS_W-1:0] position;
  logic [teb_pkg::STAMP_W-1:0]      stamp;
  logic [teb_pkg::RCNT_W-1:0]       read_count;

  modport source (
    output valid, action, event_kind, code_identity, position, stamp, read_count,
    input  ready
  );
  modport sink (
    input  valid, action, event_kind, code_identity, position, stamp, read_count,
    output ready
  );
endinterface

>>> src/teb_out_if.sv
// Result channel of the trace event ring buffer: one status or event per transfer.
interface teb_out_if;
  logic                             valid;
  logic                             ready;
  logic                             result_kind;
  logic [teb_pkg::STAMP_W-1:0]      out_stamp;
  logic [teb_pkg::CODE_W-1:0]       out_code;
  logic signed [teb_pkg::POS_W-1:0] out_position;
  logic [teb_pkg::KIND_W-1:0]       out_kind;
  logic [teb_pkg::TOTAL_W-1:0]      event_total;
  logic [teb_pkg::WIDX_W-1:0]       write_index;
  logic                             recording;
  logic                             last;

  modport source (
    output valid, result_kind, out_stamp, out_code, out_position, out_kind,
           event_total, write_index, recording, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_stamp, out_code, out_position, out_kind,
           event_total, write_index, recording, last,
    output ready
  );
endinterface

>>> src/teb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module teb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/teb_ctrl.sv
// Action decoder, ring pointers, read sequencer and output register.
module teb_ctrl #(
  parameter int DEPTH    = teb_pkg::DEPTH_DEF,
  parameter int MAX_READ = teb_pkg::MAX_READ_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [$clog2(DEPTH+1)-1:0] cap_eff,
  teb_in_if.sink                     in_if,
  teb_out_if.source                  out_if,
  output logic                       ram_we,
  output logic [$clog2(DEPTH)-1:0]   ram_waddr,
  output teb_pkg::ent_t              ram_wdata,
  output logic [$clog2(DEPTH)-1:0]   ram_raddr,
  input  teb_pkg::ent_t              ram_rdata
);
  import teb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(MAX_READ + 1);
  localparam int NW = (CW > RW) ? CW : RW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic               state_r, state_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               rec_r, rec_nxt;
  logic [AW-1:0]      rd_addr_r, rd_addr_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;

  logic               out_v_r, out_v_nxt;
  logic               out_rk_r, out_rk_nxt;
  ent_t               out_ent_r, out_ent_nxt;
  logic [TOTAL_W-1:0] out_tot_r, out_tot_nxt;
  logic [WIDX_W-1:0]  out_widx_r, out_widx_nxt;
  logic               out_rec_r, out_rec_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               accept;
  logic [AW-1:0]      eslot;
  logic [CW-1:0]      pos_inc;
  logic [RW-1:0]      n_req;
  logic [CW-1:0]      avail;
  logic [RW-1:0]      n_rd;
  logic [NW-1:0]      start_w;
  logic [CW-1:0]      addr_inc;
  logic               emit;

  assign out_free     = !out_v_r || out_if.ready;
  assign in_if.ready  = (state_r == ST_IDLE) && out_free;
  assign accept       = in_if.valid && in_if.ready;
  assign emit         = (state_r == ST_READ) && out_free;

  assign eslot   = (CW'(slot_r) < cap_eff) ? slot_r : '0;
  assign pos_inc = CW'(eslot) + CW'(1);

  assign n_req = (in_if.read_count > RCNT_W'(MAX_READ)) ? RW'(MAX_READ)
                                                       : RW'(in_if.read_count);
  assign avail = (total_r < TOTAL_W'(cap_eff)) ? CW'(total_r) : cap_eff;
  assign n_rd  = (NW'(n_req) > NW'(avail)) ? RW'(avail) : n_req;

  assign start_w = (NW'(eslot) >= NW'(n_rd)) ? NW'(eslot) - NW'(n_rd)
                                             : NW'(eslot) + NW'(cap_eff) - NW'(n_rd);
  assign addr_inc = CW'(rd_addr_r) + CW'(1);

  assign ram_we          = accept && (in_if.action == ACT_RECORD) && rec_r;
  assign ram_waddr       = eslot;
  assign ram_wdata.stamp    = in_if.stamp;
  assign ram_wdata.code     = in_if.code_identity;
  assign ram_wdata.position = in_if.position;
  assign ram_wdata.kind     = in_if.event_kind;
  assign ram_raddr       = rd_addr_nxt;

  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    total_nxt    = total_r;
    rec_nxt      = rec_r;
    rd_addr_nxt  = rd_addr_r;
    rem_nxt      = rem_r;
    out_v_nxt    = out_v_r && !out_if.ready;
    out_rk_nxt   = out_rk_r;
    out_ent_nxt  = out_ent_r;
    out_tot_nxt  = out_tot_r;
    out_widx_nxt = out_widx_r;
    out_rec_nxt  = out_rec_r;
    out_last_nxt = out_last_r;

    if (accept) begin
      unique case (in_if.action)
        ACT_RECORD: begin
          if (rec_r) begin
            slot_nxt  = (pos_inc >= cap_eff) ? '0 : AW'(pos_inc);
            total_nxt = total_r + TOTAL_W'(1);
          end
        end
        ACT_START: begin
          slot_nxt  = '0;
          total_nxt = '0;
          rec_nxt   = 1'b1;
        end
        ACT_STOP: begin
          rec_nxt = 1'b0;
        end
        ACT_CLEAR: begin
          slot_nxt  = '0;
          total_nxt = '0;
        end
        default: begin
        end
      endcase

      rd_addr_nxt = AW'(start_w);
      rem_nxt     = n_rd;

      if ((in_if.action == ACT_READ) && (n_rd != '0)) begin
        state_nxt = ST_READ;
      end else begin
        out_v_nxt    = 1'b1;
        out_rk_nxt   = RES_STATUS;
        out_ent_nxt  = '0;
        out_tot_nxt  = total_nxt;
        out_widx_nxt = WIDX_W'(slot_nxt);
        out_rec_nxt  = rec_nxt;
        out_last_nxt = 1'b1;
      end
    end else if (emit) begin
      out_v_nxt    = 1'b1;
      out_rk_nxt   = RES_EVENT;
      out_ent_nxt  = ram_rdata;
      out_tot_nxt  = total_r;
      out_widx_nxt = WIDX_W'(slot_r);
      out_rec_nxt  = rec_r;
      out_last_nxt = (rem_r == RW'(1));
      rem_nxt      = rem_r - RW'(1);
      rd_addr_nxt  = (addr_inc >= cap_eff) ? '0 : AW'(addr_inc);
      if (rem_r == RW'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      total_r <= '0;
      rec_r   <= 1'b0;
      rem_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      total_r <= total_nxt;
      rec_r   <= rec_nxt;
      rem_r   <= rem_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    out_rk_r   <= out_rk_nxt;
    out_ent_r  <= out_ent_nxt;
    out_tot_r  <= out_tot_nxt;
    out_widx_r <= out_widx_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_if.valid        = out_v_r;
  assign out_if.result_kind  = out_rk_r;
  assign out_if.out_stamp    = out_ent_r.stamp;
  assign out_if.out_code     = out_ent_r.code;
  assign out_if.out_position = out_ent_r.position;
  assign out_if.out_kind     = out_ent_r.kind;
  assign out_if.event_total  = out_tot_r;
  assign out_if.write_index  = out_widx_r;
  assign out_if.recording    = out_rec_r;
  assign out_if.last         = out_last_r;

endmodule

>>> src/trace_event_ring_buffer_core.sv
// Top level of the trace event ring buffer: capacity register, event RAM, controller.
//
// Channels: in_if takes one action per transfer (record, start, stop, clear,
// read); out_if gives result transfers, each tagged last on the final one of
// its action. cfg_we/cfg_wdata write the ring capacity; 0 acts as 1 and values
// above DEPTH act as DEPTH. Write it only while the block is idle.
// Status: a status result is registered and shows in the cycle after its action is accepted.
// A read of N events passes each event through the RAM read register and then the
// output register, oldest first, one event per cycle while out_if.ready allows; no
// action is taken until all N events have been loaded into the output register.
// Throughput: record, start, stop and clear take one per cycle unless out_if stalls;
// a read holds the input until the single RAM read port has fetched its N events.
// Reset: recording off, write index and event total zero, capacity 1024
// (clamped to DEPTH); RAM contents are not cleared and no clearing pass runs.
// Stall: the output register holds its result while out_if.ready is low, and
// the input and the read sequencer wait until it is taken.
module trace_event_ring_buffer_core #(
  parameter int DEPTH    = teb_pkg::DEPTH_DEF,
  parameter int MAX_READ = teb_pkg::MAX_READ_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  teb_in_if.sink                    in_if,
  teb_out_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic [teb_pkg::CAP_W-1:0] cfg_wdata
);
  import teb_pkg::*;

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int XW      = (CW > CAP_W) ? CW : CAP_W;
  localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  logic [CW-1:0] cap_r, cap_nxt;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  ent_t          ram_wdata;
  ent_t          ram_rdata;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cap_nxt = CW'(1);
      end else if (XW'(cfg_wdata) > XW'(DEPTH)) begin
        cap_nxt = CW'(DEPTH);
      end else begin
        cap_nxt = CW'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CW'(CAP_RST);
    end else begin
      cap_r <= cap_nxt;
    end
  end

  teb_ctrl #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_eff   (cap_r),
    .in_if     (in_if),
    .out_if    (out_if),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  teb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench of the trace event ring buffer: directed and random action traffic.
`timescale 1ns / 100ps

module testbench;
  import teb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [ACT_W-1:0]        action;
    logic [KIND_W-1:0]       kind;
    logic [CODE_W-1:0]       code;
    logic signed [POS_W-1:0] position;
    logic [STAMP_W-1:0]      stamp;
    logic [RCNT_W-1:0]       rcount;
  } trace_action_t;

  typedef struct {
    logic               kind;
    ent_t               ev;
    logic [TOTAL_W-1:0] total;
    logic [WIDX_W-1:0]  widx;
    logic               rec;
    logic               last;
  } trace_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  teb_in_if  in_ch ();
  teb_out_if out_ch ();

  trace_event_ring_buffer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow state of the ring
  ent_t               ring_mem [DEPTH_DEF];
  bit                 ring_written [DEPTH_DEF];
  int unsigned        shadow_slot;
  logic [TOTAL_W-1:0] shadow_total;
  bit                 shadow_rec;
  logic [CAP_W-1:0]   shadow_cap;

  trace_result_t expected_results [$];
  int            mismatch_count;
  bit            sender_idle;
  bit            receiver_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned ring_capacity();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > DEPTH_DEF) return DEPTH_DEF;
    return 32'(shadow_cap);
  endfunction

  function automatic int unsigned start_slot(int unsigned cap);
    return (shadow_slot < cap) ? shadow_slot : 0;
  endfunction

  function automatic int unsigned read_length(logic [RCNT_W-1:0] rc);
    int unsigned cap;
    int unsigned n;
    int unsigned avail;
    cap   = ring_capacity();
    avail = (shadow_total < 64'(cap)) ? 32'(shadow_total) : cap;
    n     = 32'(rc);
    if (n > MAX_READ_DEF) n = MAX_READ_DEF;
    if (n > avail) n = avail;
    return n;
  endfunction

  function automatic int unsigned ring_index(int unsigned n, int unsigned i);
    int unsigned cap;
    int unsigned idx;
    cap = ring_capacity();
    idx = start_slot(cap) + cap - n + i;
    if (idx >= cap) idx -= cap;
    return idx;
  endfunction

  function automatic bit read_is_safe(logic [RCNT_W-1:0] rc);
    int unsigned n;
    n = read_length(rc);
    for (int unsigned i = 0; i < n; i++)
      if (!ring_written[ring_index(n, i)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_result(logic kind, ent_t ev, logic last);
    trace_result_t r;
    r.kind  = kind;
    r.ev    = ev;
    r.total = shadow_total;
    r.widx  = shadow_slot[WIDX_W-1:0];
    r.rec   = shadow_rec;
    r.last  = last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_results(trace_action_t a);
    int unsigned cap;
    int unsigned pos;
    int unsigned n;
    cap = ring_capacity();
    unique case (a.action)
      ACT_RECORD: begin
        if (shadow_rec) begin
          pos = start_slot(cap);
          ring_mem[pos] = '{stamp: a.stamp, code: a.code, position: a.position, kind: a.kind};
          ring_written[pos] = 1'b1;
          pos++;
          shadow_slot = (pos >= cap) ? 0 : pos;
          shadow_total++;
        end
      end
      ACT_START: begin
        shadow_slot  = 0;
        shadow_total = '0;
        shadow_rec   = 1'b1;
      end
      ACT_STOP: shadow_rec = 1'b0;
      ACT_CLEAR: begin
        shadow_slot  = 0;
        shadow_total = '0;
      end
      ACT_READ: begin
        n = read_length(a.rcount);
        for (int unsigned i = 0; i < n; i++)
          push_result(RES_EVENT, ring_mem[ring_index(n, i)], i + 1 == n);
        if (n > 0) return;
      end
      default: ;
    endcase
    push_result(RES_STATUS, '0, 1'b1);
  endfunction

  function automatic trace_action_t make_action(logic [ACT_W-1:0] act,
                                                logic [RCNT_W-1:0] rc);
    trace_action_t a;
    a.action   = act;
    a.kind     = KIND_W'($urandom_range(0, 3));
    a.code     = {$urandom, $urandom};
    a.position = $urandom;
    a.stamp    = {$urandom, $urandom};
    a.rcount   = rc;
    return a;
  endfunction

  function automatic trace_action_t make_record(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                                logic signed [POS_W-1:0] position,
                                                logic [STAMP_W-1:0] stamp);
    trace_action_t a;
    a          = make_action(ACT_RECORD, RCNT_W'($urandom_range(0, 127)));
    a.kind     = kind;
    a.code     = code;
    a.position = position;
    a.stamp    = stamp;
    return a;
  endfunction

  function automatic trace_action_t random_action();
    int unsigned r;
    logic [RCNT_W-1:0] rc;
    r  = $urandom_range(0, 99);
    rc = ($urandom_range(0, 3) == 0) ? RCNT_W'($urandom_range(0, 127))
                                     : RCNT_W'($urandom_range(1, 16));
    if (!shadow_rec && $urandom_range(0, 3) != 0) return make_action(ACT_START, rc);
    if (r < 3)  return make_action(ACT_STOP, rc);
    if (r < 6)  return make_action(ACT_CLEAR, rc);
    if (r < 9)  return make_action(ACT_START, rc);
    if (r < 12) return make_action(ACT_W'($urandom_range(5, 7)), rc);
    if (r < 26) return make_action(ACT_READ, rc);
    return make_action(ACT_RECORD, rc);
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic send_action(trace_action_t a);
    int gap;
    gap = sender_idle ? $urandom_range(0, 14) : 0;
    if (a.action == ACT_READ)
      while (!read_is_safe(a.rcount)) a.rcount--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.action        <= a.action;
    in_ch.event_kind    <= a.kind;
    in_ch.code_identity <= a.code;
    in_ch.position      <= a.position;
    in_ch.stamp         <= a.stamp;
    in_ch.read_count    <= a.rcount;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_results(a);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] value);
    drain_results();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we     <= 1'b0;
    shadow_cap  = value;
  endtask

  task automatic test_actions();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    send_action(make_record(2'd1, 64'h1, 32'sd1, 64'h1));
    send_action(make_action(ACT_READ, 7'd5));
    send_action(make_action(ACT_START, 7'd0));
    send_action(make_record(2'd0, '0, 32'sh8000_0000, '0));
    send_action(make_record(2'd1, '1, 32'sh7fff_ffff, '1));
    send_action(make_record(2'd2, 64'h5555_aaaa_5555_aaaa, -32'sd1, 64'haaaa_5555_aaaa_5555));
    send_action(make_record(2'd3, 64'h0123_4567_89ab_cdef, 32'sd0, 64'hfedc_ba98_7654_3210));
    send_action(make_action(ACT_READ, 7'd127));
    send_action(make_action(ACT_READ, 7'd0));
    send_action(make_action(ACT_READ, 7'd2));
    send_action(make_action(ACT_STOP, 7'd0));
    send_action(make_record(2'd3, '1, -32'sd1, '1));
    send_action(make_action(3'd5, 7'd64));
    send_action(make_action(3'd6, 7'd1));
    send_action(make_action(3'd7, 7'd127));
    send_action(make_action(ACT_CLEAR, 7'd0));
    send_action(make_action(ACT_READ, 7'd1));
  endtask

  task automatic test_capacity_extremes();
    set_capacity('0);
    send_action(make_action(ACT_START, 7'd0));
    send_action(make_action(ACT_RECORD, 7'd0));
    send_action(make_action(ACT_RECORD, 7'd0));
    send_action(make_action(ACT_READ, 7'd127));
    set_capacity('1);
  endtask

  task automatic test_slot_past_capacity();
    send_action(make_action(ACT_START, 7'd0));
    repeat (6) send_action(make_action(ACT_RECORD, 7'd0));
    set_capacity(11'd3);
    send_action(make_action(ACT_READ, 7'd127));
    send_action(make_action(ACT_RECORD, 7'd0));
    send_action(make_action(ACT_READ, 7'd127));
  endtask

  task automatic test_random_traffic();
    int            taken;
    int            len;
    int unsigned   pick;
    trace_action_t a;
    taken = 0;
    while (taken < 180) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: set_capacity('0);
        1: set_capacity(11'd1);
        2: set_capacity(11'd2);
        3: set_capacity('1);
        4: set_capacity(11'd1024);
        5: set_capacity(CAP_W'($urandom_range(3, 12)));
        6: set_capacity(CAP_W'($urandom_range(0, 2047)));
        default: drain_results();
      endcase
      sender_idle   = $urandom_range(0, 2) != 0;
      receiver_idle = $urandom_range(0, 2) != 0;
      pick = $urandom_range(0, 5);
      if (pick < 4) begin
        send_action(make_action(ACT_START, RCNT_W'($urandom_range(0, 127))));
        taken++;
      end else if (pick == 4) begin
        send_action(make_action(ACT_CLEAR, RCNT_W'($urandom_range(0, 127))));
        taken++;
      end
      len = (ring_capacity() >= 64) ? $urandom_range(10, 90) : $urandom_range(8, 30);
      if (len > 180 - taken) len = 180 - taken;
      repeat (len) begin
        a = random_action();
        send_action(a);
        taken++;
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_RECORD;
    in_ch.event_kind    = '0;
    in_ch.code_identity = '0;
    in_ch.position      = '0;
    in_ch.stamp         = '0;
    in_ch.read_count    = '0;
    out_ch.ready        = 1'b0;
    mismatch_count      = 0;
    sender_idle         = 1'b0;
    receiver_idle       = 1'b0;
    shadow_slot         = 0;
    shadow_total        = '0;
    shadow_rec          = 1'b0;
    shadow_cap          = CAP_W'(CAP_RESET);
    foreach (ring_written[i]) ring_written[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_actions();
    test_capacity_extremes();
    test_slot_past_capacity();
    test_random_traffic();
    drain_results();
    repeat (10) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      w = receiver_idle ? $urandom_range(0, 14) : 0;
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
    end
  end

  always @(posedge clk) begin
    trace_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_results.pop_front();
        compare_field("result_kind", out_ch.result_kind, want.kind);
        compare_field("out_stamp", out_ch.out_stamp, want.ev.stamp);
        compare_field("out_code", out_ch.out_code, want.ev.code);
        compare_field("out_position", out_ch.out_position, want.ev.position);
        compare_field("out_kind", out_ch.out_kind, want.ev.kind);
        compare_field("event_total", out_ch.event_total, want.total);
        compare_field("write_index", out_ch.write_index, want.widx);
        compare_field("recording", out_ch.recording, want.rec);
        compare_field("last", out_ch.last, want.last);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

endmodule

>>> trace_event_ring_buffer_core.f
src/teb_pkg.sv
src/teb_in_if.sv
src/teb_out_if.sv
src/teb_ram.sv
src/teb_ctrl.sv
src/trace_event_ring_buffer_core.sv
dv/testbench.sv
